FILE: rtl/core/vrt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the voxel ray traversal core.
// Used by the controller, datapath and top level under rtl/core; depends on nothing else.
package vrt_pkg;

    // Item mode codes.
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // Axis codes.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Step sign codes.
    localparam logic [1:0] SIGN_NONE = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd3;

    // Ray length limit after reset: 8.0 in unsigned Q16.16.
    localparam logic [31:0] MAXD_RESET = 32'd524288;

    // Square root: one result bit per iteration over a 64-bit radicand.
    localparam logic [63:0] SQRT_BIT_INIT = 64'h4000_0000_0000_0000;
    localparam logic [4:0]  SQRT_LAST     = 5'd31;

    // Input transaction.
    typedef struct packed {
        logic               mode;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } vrt_in_t;

    // Result transaction.
    typedef struct packed {
        logic signed [15:0] voxel_x;
        logic signed [15:0] voxel_y;
        logic signed [15:0] voxel_z;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
        logic [31:0]        travelled;
        logic [1:0]         axis_stepped;
        logic               reached_limit;
        logic               exhausted;
    } vrt_out_t;

    // Controller states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_SQRT,
        ST_AX_CHECK,
        ST_DIV_U_GO,
        ST_DIV_U_WAIT,
        ST_DIV_W_GO,
        ST_DIV_W_WAIT,
        ST_BND_MUL,
        ST_BND_SET,
        ST_AX_NEXT,
        ST_FINISH,
        ST_STEP,
        ST_HIT_MUL,
        ST_HIT_ADD,
        ST_RESULT
    } vrt_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       cap_start;
        logic       sq_mul;
        logic       sq_acc;
        logic       sqrt_iter;
        logic       set_zero;
        logic       div_start;
        logic       div_w_sel;
        logic       u_load;
        logic       w_load;
        logic       bnd_mul;
        logic       bnd_set;
        logic       finish;
        logic       step_eval;
        logic       hit_mul;
        logic       hit_add;
        logic       out_load;
        logic [1:0] axis;
    } vrt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic axis_zero;
        logic out_busy;
    } vrt_sts_t;

endpackage

FILE: rtl/core/vrt_div.sv
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; instantiated by the datapath.
module vrt_div #(
    parameter int NW = 49,
    parameter int DW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW:0]   rem_sh;
    logic          ge;

    // One shift-subtract step.
    always_comb begin
        rem_sh = {rem_reg[DW-1:0], quo_reg[NW-1]};
        ge     = (rem_sh >= {1'b0, den_reg});
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end else if (busy_reg) begin
            rem_next = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_next = {quo_reg[NW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(NW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: rtl/core/vrt_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences ray setup and voxel steps.
// Depends on vrt_pkg; drives the datapath through vrt_cmd_t.
module vrt_ctrl
    import vrt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     in_mode,
    output logic     s_ready,
    input  vrt_sts_t sts,
    output vrt_cmd_t cmd
);
    vrt_state_t state_reg, state_next;
    logic [1:0] ax_reg, ax_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       ax_last;

    assign ax_last = (ax_reg == AXIS_Z);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (in_mode == MODE_START) ? ST_SQ_MUL : ST_STEP;
                end
            end
            ST_SQ_MUL:     state_next = ST_SQ_ACC;
            ST_SQ_ACC:     state_next = ax_last ? ST_SQRT : ST_SQ_MUL;
            ST_SQRT:       state_next = (cnt_reg == SQRT_LAST) ? ST_AX_CHECK : ST_SQRT;
            ST_AX_CHECK:   state_next = sts.axis_zero ? ST_AX_NEXT : ST_DIV_U_GO;
            ST_DIV_U_GO:   state_next = ST_DIV_U_WAIT;
            ST_DIV_U_WAIT: state_next = sts.div_done ? ST_DIV_W_GO : ST_DIV_U_WAIT;
            ST_DIV_W_GO:   state_next = ST_DIV_W_WAIT;
            ST_DIV_W_WAIT: state_next = sts.div_done ? ST_BND_MUL : ST_DIV_W_WAIT;
            ST_BND_MUL:    state_next = ST_BND_SET;
            ST_BND_SET:    state_next = ST_AX_NEXT;
            ST_AX_NEXT:    state_next = ax_last ? ST_FINISH : ST_AX_CHECK;
            ST_FINISH:     state_next = ST_IDLE;
            ST_STEP:       state_next = ST_HIT_MUL;
            ST_HIT_MUL:    state_next = ST_HIT_ADD;
            ST_HIT_ADD:    state_next = ax_last ? ST_RESULT : ST_HIT_MUL;
            ST_RESULT:     state_next = sts.out_busy ? ST_RESULT : ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // Axis and iteration counters.
    always_comb begin
        ax_next  = ax_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                ax_next  = AXIS_X;
                cnt_next = '0;
            end
            ST_SQ_ACC, ST_AX_NEXT, ST_HIT_ADD: begin
                ax_next = ax_last ? AXIS_X : (ax_reg + 2'd1);
            end
            ST_SQRT:  cnt_next = cnt_reg + 5'd1;
            default: begin
                ax_next = ax_reg;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        cmd      = '0;
        cmd.axis = ax_reg;
        s_ready  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.cap_start = s_valid && (in_mode == MODE_START);
            end
            ST_SQ_MUL:     cmd.sq_mul = 1'b1;
            ST_SQ_ACC:     cmd.sq_acc = 1'b1;
            ST_SQRT:       cmd.sqrt_iter = 1'b1;
            ST_AX_CHECK:   cmd.set_zero = sts.axis_zero;
            ST_DIV_U_GO:   cmd.div_start = 1'b1;
            ST_DIV_U_WAIT: cmd.u_load = sts.div_done;
            ST_DIV_W_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_w_sel = 1'b1;
            end
            ST_DIV_W_WAIT: cmd.w_load = sts.div_done;
            ST_BND_MUL:    cmd.bnd_mul = 1'b1;
            ST_BND_SET:    cmd.bnd_set = 1'b1;
            ST_FINISH:     cmd.finish = 1'b1;
            ST_STEP:       cmd.step_eval = 1'b1;
            ST_HIT_MUL:    cmd.hit_mul = 1'b1;
            ST_HIT_ADD:    cmd.hit_add = 1'b1;
            ST_RESULT:     cmd.out_load = !sts.out_busy;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ax_reg    <= AXIS_X;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ax_reg    <= ax_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: rtl/core/vrt_dp.sv
`timescale 1ns / 1ps
// Datapath: ray state, shared multiplier, square root, divider and result register.
// Depends on vrt_pkg and vrt_div; controlled by vrt_ctrl through vrt_cmd_t.
module vrt_dp
    import vrt_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int INT_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  vrt_in_t     s_data,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  vrt_cmd_t    cmd,
    output vrt_sts_t    sts,
    output logic        m_valid,
    input  logic        m_ready,
    output vrt_out_t    m_data
);
    localparam int F  = FRAC_BITS;
    localparam int IB = INT_BITS;
    localparam int UW = F + 1;
    localparam int NW = F + 33;
    localparam logic [63:0] HALF = 64'(1) << (F - 1);

    // Ray state.
    logic [31:0]   origin_reg [3], origin_next [3];
    logic [31:0]   dmag_reg   [3], dmag_next   [3];
    logic          dneg_reg   [3], dneg_next   [3];
    logic [IB-1:0] voxel_reg  [3], voxel_next  [3];
    logic [UW-1:0] umag_reg   [3], umag_next   [3];
    logic [1:0]    sign_reg   [3], sign_next   [3];
    logic [31:0]   weight_reg [3], weight_next [3];
    logic [31:0]   bnd_reg    [3], bnd_next    [3];
    logic [31:0]   hit_reg    [3], hit_next    [3];
    logic [31:0]   dist_reg, dist_next;
    logic          active_reg, active_next;
    logic [31:0]   maxd_reg, maxd_next;

    // Setup arithmetic.
    logic [63:0] acc_reg, acc_next;
    logic [63:0] root_reg, root_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] prod_reg;

    // Step result.
    logic [31:0] rt_reg, rt_next;
    logic [1:0]  rax_reg, rax_next;
    logic        rlim_reg, rlim_next;
    logic        rexh_reg, rexh_next;

    // Output register.
    vrt_out_t out_reg, out_next;
    logic     out_valid_reg, out_valid_next;

    logic [1:0]    ax;
    logic [31:0]   len;
    logic [31:0]   mul_a, mul_b;
    logic          mul_en;
    logic [NW-1:0] div_num, div_quo;
    logic [31:0]   div_den;
    logic          div_done;
    logic [F:0]    delta;
    logic [63:0]   rsum, rnd, rshift;
    logic [32:0]   key [3];
    logic [1:0]    sel;
    logic [32:0]   bsum;
    logic [31:0]   t_sel;
    logic          exh;
    logic [35:0]   off36, hsum;
    logic [IB+31:0] vext;
    logic [IB+15:0] vout [3];
    logic [31:0]   s_org [3];
    logic [31:0]   s_dir [3];

    assign ax  = cmd.axis;
    assign len = root_reg[31:0];

    assign s_org[0] = s_data.start_x;
    assign s_org[1] = s_data.start_y;
    assign s_org[2] = s_data.start_z;
    assign s_dir[0] = s_data.dir_x;
    assign s_dir[1] = s_data.dir_y;
    assign s_dir[2] = s_data.dir_z;

    // Distance to the first plane in the step direction.
    assign delta = dneg_reg[ax] ? {1'b0, origin_reg[ax][F-1:0]}
                                : ((F+1)'(1) << F) - {1'b0, origin_reg[ax][F-1:0]};

    // Shared multiplier operand selection.
    always_comb begin
        mul_a  = dmag_reg[ax];
        mul_b  = dmag_reg[ax];
        mul_en = cmd.sq_mul || cmd.bnd_mul || cmd.hit_mul;
        if (cmd.bnd_mul) begin
            mul_a = 32'(delta);
            mul_b = weight_reg[ax];
        end else if (cmd.hit_mul) begin
            mul_a = 32'(umag_reg[ax]);
            mul_b = rt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= 64'(mul_a) * 64'(mul_b);
        end
    end

    // Divider operands: unit component or axis weight.
    always_comb begin
        if (cmd.div_w_sel) begin
            div_num = {1'b0, len, {F{1'b0}}} + NW'(dmag_reg[ax][31:1]);
            div_den = dmag_reg[ax];
        end else begin
            div_num = {1'b0, dmag_reg[ax], {F{1'b0}}} + NW'(len[31:1]);
            div_den = len;
        end
    end

    vrt_div #(
        .NW (NW),
        .DW (32)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Square root step, rounding of the product and axis selection.
    always_comb begin
        rsum   = root_reg + bit_reg;
        rnd    = prod_reg + HALF;
        rshift = rnd >> F;
        for (int a = 0; a < 3; a++) begin
            key[a] = (sign_reg[a] != SIGN_NONE) ? {1'b0, bnd_reg[a]} : {1'b1, 32'd0};
        end
        if (key[0] < key[1]) begin
            sel = (key[0] < key[2]) ? AXIS_X : AXIS_Z;
        end else begin
            sel = (key[1] < key[2]) ? AXIS_Y : AXIS_Z;
        end
        t_sel = bnd_reg[sel];
        bsum  = {1'b0, t_sel} + {1'b0, weight_reg[sel]};
        exh   = !active_reg || (dist_reg >= maxd_reg);
        off36 = rshift[35:0];
        hsum  = (sign_reg[ax] == SIGN_NEG)
              ? ({{4{origin_reg[ax][31]}}, origin_reg[ax]} - off36)
              : ({{4{origin_reg[ax][31]}}, origin_reg[ax]} + off36);
        for (int a = 0; a < 3; a++) begin
            vout[a] = {16'd0, voxel_reg[a]};
        end
    end

    // Next-state logic for the datapath registers.
    always_comb begin
        vext = '0;
        for (int a = 0; a < 3; a++) begin
            origin_next[a] = origin_reg[a];
            dmag_next[a]   = dmag_reg[a];
            dneg_next[a]   = dneg_reg[a];
            voxel_next[a]  = voxel_reg[a];
            umag_next[a]   = umag_reg[a];
            sign_next[a]   = sign_reg[a];
            weight_next[a] = weight_reg[a];
            bnd_next[a]    = bnd_reg[a];
            hit_next[a]    = hit_reg[a];
        end
        dist_next      = dist_reg;
        active_next    = active_reg;
        maxd_next      = cfg_wr_en ? cfg_wr_data : maxd_reg;
        acc_next       = acc_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        rt_next        = rt_reg;
        rax_next       = rax_reg;
        rlim_next      = rlim_reg;
        rexh_next      = rexh_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;

        // Load a new ray: origin, direction magnitude and the voxel of the origin.
        if (cmd.cap_start) begin
            for (int a = 0; a < 3; a++) begin
                origin_next[a] = s_org[a];
                dneg_next[a]   = s_dir[a][31];
                dmag_next[a]   = s_dir[a][31] ? (32'd0 - s_dir[a]) : s_dir[a];
                vext           = {{IB{s_org[a][31]}}, 32'($signed(s_org[a]) >>> F)};
                voxel_next[a]  = vext[IB-1:0];
            end
            acc_next  = '0;
            root_next = '0;
            bit_next  = SQRT_BIT_INIT;
        end

        // Sum of squares.
        if (cmd.sq_acc) begin
            acc_next = acc_reg + prod_reg;
        end

        // Integer square root, one bit per cycle.
        if (cmd.sqrt_iter) begin
            if (acc_reg >= rsum) begin
                acc_next  = acc_reg - rsum;
                root_next = (root_reg >> 1) + bit_reg;
            end else begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end

        // An axis with no direction never steps.
        if (cmd.set_zero) begin
            umag_next[ax]   = '0;
            sign_next[ax]   = SIGN_NONE;
            weight_next[ax] = '1;
            bnd_next[ax]    = '1;
        end

        if (cmd.u_load) begin
            umag_next[ax] = div_quo[UW-1:0];
            sign_next[ax] = dneg_reg[ax] ? SIGN_NEG : SIGN_POS;
        end

        if (cmd.w_load) begin
            weight_next[ax] = (div_quo[NW-1:32] != '0) ? '1 : div_quo[31:0];
        end

        if (cmd.bnd_set) begin
            bnd_next[ax] = (rshift[63:32] != '0) ? '1 : rshift[31:0];
        end

        if (cmd.finish) begin
            dist_next   = '0;
            active_next = (sign_reg[0] != SIGN_NONE) || (sign_reg[1] != SIGN_NONE)
                       || (sign_reg[2] != SIGN_NONE);
        end

        // One voxel step, or an exhausted report.
        if (cmd.step_eval) begin
            if (exh) begin
                active_next = 1'b0;
                rt_next     = dist_reg;
                rax_next    = AXIS_X;
                rlim_next   = 1'b0;
                rexh_next   = 1'b1;
            end else begin
                voxel_next[sel] = (sign_reg[sel] == SIGN_NEG)
                                ? (voxel_reg[sel] - IB'(1)) : (voxel_reg[sel] + IB'(1));
                bnd_next[sel]   = bsum[32] ? '1 : bsum[31:0];
                dist_next       = t_sel;
                rt_next         = t_sel;
                rax_next        = sel;
                rlim_next       = (t_sel >= maxd_reg);
                rexh_next       = 1'b0;
                if (t_sel >= maxd_reg) begin
                    active_next = 1'b0;
                end
            end
        end

        // Crossing point of one axis, saturated to the signed 32-bit range.
        if (cmd.hit_add) begin
            if (!hsum[35] && (hsum[34:31] != 4'd0)) begin
                hit_next[ax] = 32'h7FFF_FFFF;
            end else if (hsum[35] && (hsum[34:31] != 4'hF)) begin
                hit_next[ax] = 32'h8000_0000;
            end else begin
                hit_next[ax] = hsum[31:0];
            end
        end

        if (cmd.out_load) begin
            out_valid_next        = 1'b1;
            out_next.voxel_x       = vout[0][15:0];
            out_next.voxel_y       = vout[1][15:0];
            out_next.voxel_z       = vout[2][15:0];
            out_next.hit_x         = hit_reg[0];
            out_next.hit_y         = hit_reg[1];
            out_next.hit_z         = hit_reg[2];
            out_next.travelled     = rt_reg;
            out_next.axis_stepped  = rax_reg;
            out_next.reached_limit = rlim_reg;
            out_next.exhausted     = rexh_reg;
        end
    end

    // Registers whose values are visible after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                origin_reg[a] <= '0;
                voxel_reg[a]  <= '0;
                umag_reg[a]   <= '0;
                sign_reg[a]   <= SIGN_NONE;
            end
            dist_reg      <= '0;
            active_reg    <= 1'b0;
            maxd_reg      <= MAXD_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            for (int a = 0; a < 3; a++) begin
                origin_reg[a] <= origin_next[a];
                voxel_reg[a]  <= voxel_next[a];
                umag_reg[a]   <= umag_next[a];
                sign_reg[a]   <= sign_next[a];
            end
            dist_reg      <= dist_next;
            active_reg    <= active_next;
            maxd_reg      <= maxd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        for (int a = 0; a < 3; a++) begin
            dmag_reg[a]   <= dmag_next[a];
            dneg_reg[a]   <= dneg_next[a];
            weight_reg[a] <= weight_next[a];
            bnd_reg[a]    <= bnd_next[a];
            hit_reg[a]    <= hit_next[a];
        end
        acc_reg  <= acc_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        rt_reg   <= rt_next;
        rax_reg  <= rax_next;
        rlim_reg <= rlim_next;
        rexh_reg <= rexh_next;
        out_reg  <= out_next;
    end

    assign sts.div_done  = div_done;
    assign sts.axis_zero = (dmag_reg[ax] == '0) || (len == '0);
    assign sts.out_busy  = out_valid_reg && !m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: rtl/core/voxel_ray_traversal_3d_core.sv
`timescale 1ns / 1ps
// Top level of the 3D voxel ray traversal core.
// Depends on vrt_pkg, vrt_ctrl, vrt_dp and vrt_div.
//
// Usage:
// - Input channel s_valid/s_ready/s_data carries one transaction per item. A start item
//   (mode 0) loads origin and direction and produces no result. A step item (mode 1)
//   produces exactly one result transaction on m_valid/m_ready/m_data.
// - cfg_wr_en/cfg_wr_data write max_distance (unsigned Q16.16, 8.0 after reset); write
//   it only while no item is in progress.
// - A start item occupies the core through three squares on the shared multiplier, a
//   square root that yields one result bit per iteration, then per axis two divisions
//   on the bit-serial divider and a boundary multiply, and one closing step. An axis
//   with no direction skips its divisions and its boundary multiply.
// - A step item runs one step evaluation, then one multiply and one add per axis for the
//   crossing point on the shared multiplier, then the output register load. The next
//   item is accepted in the cycle after the load, so the core takes no new item before
//   the last one is through.
// - The output register holds a finished result while the core accepts the next item;
//   if the receiver stalls, a later result waits in the core and s_ready stays low.
// - Reset (aresetn, synchronous, active low) clears the ray: a step before any start
//   reports exhausted at voxel 0.
module voxel_ray_traversal_3d_core
    import vrt_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int INT_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  vrt_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output vrt_out_t    m_data,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);
    vrt_cmd_t cmd;
    vrt_sts_t sts;

    vrt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .in_mode (s_data.mode),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    vrt_dp #(
        .FRAC_BITS (FRAC_BITS),
        .INT_BITS  (INT_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // An accepted transaction always makes the core busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("core ready right after accepting a transaction");

    // An exhausted report never claims the limit or a stepped axis.
    a_exhausted_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.exhausted |-> !m_data.reached_limit && m_data.axis_stepped == AXIS_X)
        else $error("exhausted result with limit flag or axis set");

    // The stepped axis code is always a real axis.
    a_axis_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.axis_stepped != 2'd3)
        else $error("invalid axis code on result");

endmodule
